// ===== hw/rtl/median_filter_3x3_replicate_assert.svh =====
// assertion macros for the 3x3 median filter
// the using module must provide clk and rst (synchronous, active high)
`ifndef MEDIAN_FILTER_3X3_REPLICATE_ASSERT_SVH
`define MEDIAN_FILTER_3X3_REPLICATE_ASSERT_SVH

// condition checked in the same cycle as its trigger
`define MF3_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition checked in the cycle after its trigger
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mf3_pkg.sv =====
// shared types and constants for the 3x3 median filter
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package mf3_pkg;

  // parameter defaults
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;
  localparam int PIXEL_BITS_DEF = 16;

  // fixed field widths
  localparam int PIX_W       = 16;
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 2;

  typedef logic [PIX_W-1:0] pix_t;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  // input item kinds
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // compare-exchange network for the middle of nine
  localparam int NET_STEPS = 19;
  localparam logic [3:0] NET_LO [NET_STEPS] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4};
  localparam logic [3:0] NET_HI [NET_STEPS] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2};

endpackage

`default_nettype wire

// ===== hw/rtl/mf3_if.sv =====
// valid/ready channel interfaces for pixel items and median items
// depends on mf3_pkg
`default_nettype none

interface mf3_pixel_if;
  import mf3_pkg::*;
  logic valid;
  logic ready;
  logic mode;
  pix_t pixel;

  modport source (output valid, output mode, output pixel, input ready);
  modport sink   (input valid, input mode, input pixel, output ready);
endinterface

interface mf3_median_if;
  import mf3_pkg::*;
  logic valid;
  logic ready;
  pix_t median;
  logic frame_last;

  modport source (output valid, output median, output frame_last, input ready);
  modport sink   (input valid, input median, input frame_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/median_filter_3x3_replicate.sv =====
// each accepted item that yields a result passes the window stage register, then the
// median network into the output register; by position each output trails its pixel
// by frame_width+1 items. throughput: 1 item per cycle while the output is not
// stalled, one line-store read and write per item. reset (sync, rst high) clears
// counters and pipeline valids and sets 640x480; line stores get no clearing pass.
`default_nettype none

`include "median_filter_3x3_replicate_assert.svh"

module median_filter_3x3_replicate #(
  parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mf3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]        cfg_data,
  mf3_pixel_if.sink                        pixels,
  mf3_median_if.source                     medians
);
  import mf3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CNT_W = COL_W + 1;
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

  typedef logic [PIXEL_BITS-1:0] val_t;

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             cfg_hit;
  logic [31:0]      w_sel;
  logic [31:0]      h_sel;
  logic [CNT_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;

  // position counters
  logic [COL_W-1:0] input_column;
  logic [COL_W-1:0] input_column_next;
  logic [ROW_W-1:0] input_row;
  logic [ROW_W-1:0] input_row_next;
  logic [COL_W-1:0] output_column;
  logic [COL_W-1:0] output_column_next;
  logic [ROW_W-1:0] output_row;
  logic [ROW_W-1:0] output_row_next;
  logic             frame_done;
  logic             frame_done_next;

  // line stores
  val_t mem_upper  [MAX_WIDTH];
  val_t mem_middle [MAX_WIDTH];
  val_t rd_upper;
  val_t rd_middle;
  logic mem_we;

  // window and step decode
  val_t             win      [9];
  val_t             win_next [9];
  val_t             up;
  val_t             bot_raw;
  val_t             bot;
  logic             acc;
  logic             take;
  logic             live;
  logic             emit_a;
  logic             emit_b;
  logic             emit;
  logic             last_flag;
  logic [CNT_W-1:0] ic_inc;
  logic [CNT_W-1:0] oc_inc;
  logic [ROW_W-1:0] ir_inc;
  logic             col_ok;
  logic             done_ok;
  val_t             sel [9];

  // pipeline
  logic s1_valid;
  val_t s1_vals [9];
  logic s1_last;
  logic out_valid;
  pix_t out_median;
  logic out_last;
  logic out_free;
  val_t nv [9];

  // effective frame size, saturated to the supported range
  assign cfg_hit = cfg_write &&
                   (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_comb begin
    w_sel = 32'(frame_width);
    if (w_sel < 32'd2) w_sel = 32'd2;
    if (w_sel > 32'(MAX_WIDTH)) w_sel = 32'(MAX_WIDTH);
    h_sel = 32'(frame_height);
    if (h_sel < 32'd1) h_sel = 32'd1;
    if (h_sel > 32'(MAX_HEIGHT)) h_sel = 32'(MAX_HEIGHT);
  end

  assign eff_w = w_sel[CNT_W-1:0];
  assign eff_h = h_sel[ROW_W-1:0];

  // handshake and item decode
  assign out_free     = !out_valid || medians.ready;
  assign pixels.ready = !s1_valid || out_free;
  assign acc          = pixels.valid && pixels.ready;
  assign take         = acc && ((pixels.mode == MODE_FLUSH) == frame_done);

  assign ic_inc = {1'b0, input_column} + CNT_W'(1);
  assign oc_inc = {1'b0, output_column} + CNT_W'(1);
  assign ir_inc = input_row + ROW_W'(1);
  assign live   = input_row <= eff_h;
  assign emit_a = (input_column == '0) && (input_row >= ROW_W'(2));
  assign emit_b = live && (input_column != '0) && (input_row != '0);
  assign emit   = take && (emit_a || emit_b);

  assign last_flag = (oc_inc == eff_w) && ((output_row + ROW_W'(1)) == eff_h);

  // new column: replicate the top and bottom rows at the frame edges
  always_comb begin
    up      = (input_row == ROW_W'(1)) ? rd_middle : rd_upper;
    bot_raw = frame_done ? rd_middle : pixels.pixel[PIXEL_BITS-1:0];
    bot     = (input_row == eff_h) ? rd_middle : bot_raw;
  end

  assign mem_we = take && live && !frame_done;

  // window shift
  always_comb begin
    win_next = win;
    if (take && live) begin
      for (int k = 0; k < 6; k++) win_next[k] = win[k + 3];
      win_next[6] = up;
      win_next[7] = rd_middle;
      win_next[8] = bot;
    end
  end

  // pick the nine neighbors; first column replicates its left edge,
  // the row's last column (emitted one item late) replicates its right edge
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (emit_a) begin
        sel[3*r]     = win[3 + r];
        sel[3*r + 1] = win[6 + r];
        sel[3*r + 2] = win[6 + r];
      end else begin
        sel[3*r]     = (input_column == COL_W'(1)) ? win_next[3 + r] : win_next[r];
        sel[3*r + 1] = win_next[3 + r];
        sel[3*r + 2] = win_next[6 + r];
      end
    end
  end

  // next counter values
  always_comb begin
    input_column_next  = input_column;
    input_row_next     = input_row;
    frame_done_next    = frame_done;
    output_column_next = output_column;
    output_row_next    = output_row;
    if (emit) begin
      if (oc_inc >= eff_w) begin
        output_column_next = '0;
        output_row_next    = output_row + ROW_W'(1);
      end else begin
        output_column_next = oc_inc[COL_W-1:0];
      end
    end
    if (take) begin
      if (!live) begin
        input_column_next  = '0;
        input_row_next     = '0;
        frame_done_next    = 1'b0;
        output_column_next = '0;
        output_row_next    = '0;
      end else if (ic_inc >= eff_w) begin
        input_column_next = '0;
        input_row_next    = ir_inc;
        if (ir_inc == eff_h) frame_done_next = 1'b1;
      end else begin
        input_column_next = ic_inc[COL_W-1:0];
      end
    end
    if (cfg_hit) begin
      input_column_next  = '0;
      input_row_next     = '0;
      frame_done_next    = 1'b0;
      output_column_next = '0;
      output_row_next    = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RESET;
      frame_height  <= FRAME_HEIGHT_RESET;
      input_column  <= '0;
      input_row     <= '0;
      output_column <= '0;
      output_row    <= '0;
      frame_done    <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
      if (cfg_write && cfg_index == REG_FRAME_HEIGHT) frame_height <= cfg_data;
      input_column  <= input_column_next;
      input_row     <= input_row_next;
      output_column <= output_column_next;
      output_row    <= output_row_next;
      frame_done    <= frame_done_next;
    end
  end

  // line stores: read ahead at the column the next item will use
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_upper[input_column]  <= rd_middle;
      mem_middle[input_column] <= bot_raw;
    end
    rd_upper  <= mem_upper[input_column_next];
    rd_middle <= mem_middle[input_column_next];
  end

  // window registers
  always_ff @(posedge clk) begin
    win <= win_next;
  end

  // window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pixels.ready && emit) begin
      s1_vals <= sel;
      s1_last <= last_flag;
    end
  end

  // median network
  always_comb begin
    val_t lo_v;
    val_t hi_v;
    nv = s1_vals;
    for (int k = 0; k < NET_STEPS; k++) begin
      lo_v = nv[NET_LO[k]];
      hi_v = nv[NET_HI[k]];
      if (lo_v > hi_v) begin
        nv[NET_LO[k]] = hi_v;
        nv[NET_HI[k]] = lo_v;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_median <= PIX_W'(nv[4]);
      out_last   <= s1_last;
    end
  end

  assign medians.valid      = out_valid;
  assign medians.median     = out_median;
  assign medians.frame_last = out_last;

  // checks
  assign col_ok  = {1'b0, input_column} < eff_w;
  assign done_ok = frame_done == (input_row >= eff_h);

  `MF3_ASSERT_SAME(a_col_range, 1'b1, col_ok, "input column beyond frame width")
  `MF3_ASSERT_SAME(a_done_row, 1'b1, done_ok, "flush phase disagrees with input row")
  `MF3_ASSERT_NEXT(a_last_restart, emit && last_flag, input_row == '0 && !frame_done,
                   "frame end marked without frame restart")

endmodule

`default_nettype wire

// ===== tb/median_filter_3x3_replicate_tb.sv =====
// self-checking testbench for the streaming 3x3 median filter with replicated edges
// depends on mf3_pkg, mf3_if and median_filter_3x3_replicate from the rtl folder
`timescale 1ns / 100ps

module median_filter_3x3_replicate_tb;
  import mf3_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int LINE_DEPTH    = MAX_WIDTH_DEF;
  localparam int ROW_LIMIT     = MAX_HEIGHT_DEF;
  localparam int RANDOM_ITEMS  = 240;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 4000;

  // register indexes the block does not implement
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic mode;
    pix_t pixel;
  } pixel_item_t;

  typedef struct packed {
    pix_t median;
    logic frame_last;
  } median_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_mode = MODE_PIXEL;
  pix_t in_pixel = '0;
  logic out_ready = 1'b0;

  mf3_pixel_if pixels();
  mf3_median_if medians();

  assign pixels.valid = in_valid;
  assign pixels.mode  = in_mode;
  assign pixels.pixel = in_pixel;
  assign medians.ready = out_ready;

  median_filter_3x3_replicate i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .medians   (medians)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // stimulus and expectation stores
  pixel_item_t pending_pixels[$];
  median_item_t medians_due[$];
  int send_idle_pct = 9;
  int recv_idle_pct = 53;
  int hold_requests = 0;
  int mismatch_count = 0;

  // filter state mirrored in the testbench
  pix_t older_row [LINE_DEPTH] = '{default: '0};
  pix_t prior_row [LINE_DEPTH] = '{default: '0};
  pix_t win [9] = '{default: '0};
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  bit flushing = 1'b0;
  logic [CFG_W-1:0] width_setting = FRAME_WIDTH_RESET;
  logic [CFG_W-1:0] height_setting = FRAME_HEIGHT_RESET;

  function automatic int unsigned used_width(logic [CFG_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > LINE_DEPTH) return LINE_DEPTH;
    return raw;
  endfunction

  function automatic int unsigned used_height(logic [CFG_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > ROW_LIMIT) return ROW_LIMIT;
    return raw;
  endfunction

  function automatic void rewind_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    flushing = 1'b0;
  endfunction

  // fifth smallest of the three window columns named by slot
  function automatic pix_t middle_of_window(int col_l, int col_c, int col_r);
    pix_t vals [9];
    pix_t held;
    int j;
    for (int r = 0; r < 3; r++) begin
      vals[3*r]   = win[3*col_l + r];
      vals[3*r+1] = win[3*col_c + r];
      vals[3*r+2] = win[3*col_r + r];
    end
    for (int i = 1; i < 9; i++) begin
      held = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > held) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = held;
    end
    return vals[4];
  endfunction

  function automatic median_item_t emit_median(pix_t med, int unsigned w, int unsigned h);
    median_item_t r;
    r.median = med;
    r.frame_last = (out_row == h - 1) && (out_col == w - 1);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    return r;
  endfunction

  // one accepted item through the filter; returns 1 when it releases a median
  function automatic bit advance_filter(pixel_item_t it, output median_item_t res);
    int unsigned w, h, ir, ic;
    pix_t up, mid, bot;
    bit got;
    w = used_width(width_setting);
    h = used_height(height_setting);
    ir = in_row;
    ic = in_col;
    got = 1'b0;
    res = '0;
    // wrong kind of item for the current phase is dropped
    if ((it.mode == MODE_FLUSH) != flushing) return 1'b0;
    // last column of the row two back leaves at the start of a row
    if (ic == 0 && ir >= 2) begin
      res = emit_median(middle_of_window(1, 2, 2), w, h);
      got = 1'b1;
    end
    if (ir <= h) begin
      up = older_row[ic];
      mid = prior_row[ic];
      if (!flushing) begin
        bot = it.pixel;
        older_row[ic] = mid;
        prior_row[ic] = bot;
      end else begin
        bot = mid;
      end
      // replicate top and bottom borders
      if (ir == 1) up = mid;
      if (ir == h) bot = mid;
      for (int k = 0; k < 6; k++) win[k] = win[k + 3];
      win[6] = up;
      win[7] = mid;
      win[8] = bot;
      if (ic >= 1 && ir >= 1) begin
        res = emit_median(middle_of_window((ic == 1) ? 1 : 0, 1, 2), w, h);
        got = 1'b1;
      end
    end
    if (ir > h) begin
      rewind_frame();
      return got;
    end
    ic++;
    if (ic >= w) begin
      ic = 0;
      ir++;
      if (ir == h) flushing = 1'b1;
    end
    in_col = ic;
    in_row = ir;
    return got;
  endfunction

  // item driver
  always @(posedge clk) begin : drive_pixels
    pixel_item_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || pixels.ready) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_mode <= next_item.mode;
        in_pixel <= next_item.pixel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with an occasional long hold-off
  int hold_left = 0;
  int hold_served = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_ready <= 1'b0;
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // prediction, result checking and watchdog
  int quiet_cycles = 0;
  always @(posedge clk) begin : check_medians
    pixel_item_t took;
    median_item_t made, want, seen;
    bit took_in, took_out;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      took_in = pixels.valid && pixels.ready;
      took_out = medians.valid && medians.ready;
      if (took_in) begin
        took.mode = pixels.mode;
        took.pixel = pixels.pixel;
        if (advance_filter(took, made)) medians_due.push_back(made);
      end
      if (took_out) begin
        seen.median = medians.median;
        seen.frame_last = medians.frame_last;
        if (medians_due.size() == 0) begin
          $error("unexpected median item: median %0d frame_last %0d",
                 seen.median, seen.frame_last);
          mismatch_count++;
        end else begin
          want = medians_due.pop_front();
          if (seen.median !== want.median) begin
            $error("median: expected %0d, got %0d", want.median, seen.median);
            mismatch_count++;
          end
          if (seen.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, seen.frame_last);
            mismatch_count++;
          end
        end
      end
      if (took_in || took_out) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic void push_item(logic mode, pix_t value);
    pixel_item_t it;
    it.mode = mode;
    it.pixel = value;
    pending_pixels.push_back(it);
  endfunction

  // mix of rails, small values for ties and full-range noise
  function automatic pix_t random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return pix_t'($urandom_range(3));
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || medians_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_FRAME_WIDTH: begin
        width_setting = value;
        rewind_frame();
      end
      REG_FRAME_HEIGHT: begin
        height_setting = value;
        rewind_frame();
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // pixels of a frame and optionally its flush ticks, with stray items of the wrong kind when noisy
  task automatic queue_frame(int unsigned npix, int unsigned nflush, bit noisy,
                             inout int unsigned counted);
    for (int unsigned i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(15) == 0) push_item(MODE_FLUSH, random_pixel());
      push_item(MODE_PIXEL, random_pixel());
    end
    for (int unsigned i = 0; i < nflush; i++) begin
      if (noisy && $urandom_range(15) == 0) push_item(MODE_PIXEL, random_pixel());
      push_item(MODE_FLUSH, random_pixel());
    end
    counted += npix + nflush;
  endtask

  initial begin
    int unsigned w, h, npix, counted, spare;
    logic [CFG_W-1:0] w_raw, h_raw;
    bit broken, restart_due;
    counted = 0;
    spare = 0;
    restart_due = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: a bit past one 640 row shows the first medians
    queue_frame(645, 0, 1'b0, spare);
    wait_drained();

    // narrowest, shortest frame: raw zeros clamp to 2x1, stray items ignored
    write_register(REG_FRAME_WIDTH, 12'd0);
    write_register(REG_FRAME_HEIGHT, 12'd0);
    push_item(MODE_FLUSH, 16'h1234);
    push_item(MODE_PIXEL, 16'h0000);
    push_item(MODE_PIXEL, 16'hFFFF);
    push_item(MODE_PIXEL, 16'hA5A5);
    repeat (3) push_item(MODE_FLUSH, 16'hFFFF);
    wait_drained();

    // width 1 clamps to 2; sender pauses mid-frame until the medians are back
    write_register(REG_FRAME_WIDTH, 12'd1);
    write_register(REG_FRAME_HEIGHT, 12'd3);
    push_item(MODE_PIXEL, 16'h8000);
    push_item(MODE_PIXEL, 16'h7FFF);
    push_item(MODE_PIXEL, 16'hFFFF);
    push_item(MODE_PIXEL, 16'h0000);
    wait_drained();
    push_item(MODE_PIXEL, 16'hFFFF);
    push_item(MODE_PIXEL, 16'h0001);
    repeat (3) push_item(MODE_FLUSH, 16'h0000);
    wait_drained();

    // writes to unused indexes change nothing and do not restart the frame
    write_register(REG_FRAME_WIDTH, 12'd3);
    write_register(REG_FRAME_HEIGHT, 12'd2);
    push_item(MODE_PIXEL, 16'hFFFF);
    push_item(MODE_PIXEL, 16'h0000);
    push_item(MODE_PIXEL, 16'hFFFF);
    push_item(MODE_PIXEL, 16'h0000);
    wait_drained();
    write_register(REG_SPARE_2, 12'hFFF);
    write_register(REG_SPARE_3, 12'h000);
    push_item(MODE_PIXEL, 16'h5555);
    push_item(MODE_PIXEL, 16'hAAAA);
    repeat (4) push_item(MODE_FLUSH, 16'h5A5A);
    wait_drained();

    // random small frames, some cut short and restarted by a register write
    while (counted < RANDOM_ITEMS) begin
      if (counted >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (counted >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 9;
      end
      if (restart_due || $urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: w_raw = CFG_W'($urandom_range(1));
          1: w_raw = CFG_W'($urandom_range(40, 11));
          default: w_raw = CFG_W'($urandom_range(10, 2));
        endcase
        h_raw = ($urandom_range(7) == 0) ? '0 : CFG_W'($urandom_range(6, 1));
        wait_drained();
        write_register(REG_FRAME_WIDTH, w_raw);
        write_register(REG_FRAME_HEIGHT, h_raw);
        restart_due = 1'b0;
      end
      w = used_width(width_setting);
      h = used_height(height_setting);
      broken = ($urandom_range(5) == 0);
      npix = broken ? $urandom_range(w * h - 1) : w * h;
      queue_frame(npix, broken ? 0 : w + 1, 1'b1, counted);
      restart_due = broken;
    end
    wait_drained();

    // height register at its top clamps to the row limit; frame cut short
    write_register(REG_FRAME_WIDTH, 12'd3);
    write_register(REG_FRAME_HEIGHT, 12'hFFF);
    queue_frame(12, 0, 1'b0, spare);
    wait_drained();

    // long receiver hold-off while items keep coming
    write_register(REG_FRAME_WIDTH, 12'd24);
    write_register(REG_FRAME_HEIGHT, 12'd4);
    queue_frame(96, 25, 1'b0, spare);
    hold_requests++;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_if.sv
hw/rtl/median_filter_3x3_replicate.sv
tb/median_filter_3x3_replicate_tb.sv
